// ===== design/first_fit_block_allocator_assert.svh =====
// Assertion macros for the first-fit allocator; they expect clk and rst_n in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: sequence check failed");
`else
`define FFBA_ASSERT(label, cond)
`define FFBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

    // Width of offsets and sizes inside the segment table; covers arenas up to 128 KiB.
    localparam int SEG_W = 17;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_BAD_ADDRESS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SET_HIT,
        OP_INSERT,
        OP_REMOVE_AFTER,
        OP_REMOVE_HIT
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT,
        S_ALLOC,
        S_FREE_A,
        S_FREE_B,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [SEG_W-1:0] offset;
        logic [SEG_W-1:0] size;
        logic             free;
    } seg_t;

    // What a cell shows its neighbors and the controller
    typedef struct packed {
        seg_t seg;
        logic tok;
        logic hit;
    } link_t;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic             start;
        logic             shift_tok;
        logic             latch_hit;
        cell_op_t         op;
        logic [SEG_W-1:0] wr_size;
        logic             wr_free;
        logic [SEG_W-1:0] new_offset;
        logic [SEG_W-1:0] new_size;
    } cell_cmd_t;

endpackage

// ===== design/ffba_req_if.sv =====
`timescale 1ns / 1ps
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [13:0] request_size;
    logic [12:0] block_address;

    modport source (output valid, mode, request_size, block_address, input ready);
    modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

// ===== design/ffba_rsp_if.sv =====
`timescale 1ns / 1ps
interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [12:0] granted_address;
    logic [13:0] granted_size;

    modport source (output valid, status, granted_address, granted_size, input ready);
    modport sink (input valid, status, granted_address, granted_size, output ready);
endinterface

// ===== design/ffba_cell.sv =====
`timescale 1ns / 1ps
module ffba_cell #(
    parameter bit IS_FIRST  = 1'b0,
    parameter int INIT_SIZE = 8168
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffba_pkg::cell_cmd_t cmd,
    input  ffba_pkg::link_t    lo,
    input  ffba_pkg::link_t    hi,
    output ffba_pkg::link_t    me
);
    import ffba_pkg::*;

    localparam seg_t RESET_SEG = IS_FIRST ?
        seg_t'{valid: 1'b1, offset: '0, size: SEG_W'(INIT_SIZE), free: 1'b1} : seg_t'('0);

    seg_t seg_reg, seg_next;
    logic tok_reg, tok_next;
    logic hit_reg, hit_next;
    logic vis_reg, vis_next;

    // Scan token, hit mark and shift moves with the neighbors
    always_comb
    begin
        seg_next = seg_reg;
        tok_next = tok_reg;
        hit_next = hit_reg;
        vis_next = vis_reg;
        if (cmd.start)
        begin
            tok_next = IS_FIRST;
            hit_next = 1'b0;
            vis_next = 1'b0;
        end
        if (cmd.shift_tok)
        begin
            tok_next = lo.tok;
            vis_next = vis_reg | tok_reg;
            if (cmd.latch_hit)
            begin
                hit_next = tok_reg;
                vis_next = 1'b1 & (vis_reg | tok_reg);
            end
        end
        case (cmd.op)
            OP_SET_HIT:
            begin
                if (hit_reg)
                begin
                    seg_next.size = cmd.wr_size;
                    seg_next.free = cmd.wr_free;
                end
            end
            OP_INSERT:
            begin
                if (hit_reg)
                begin
                    seg_next.size = cmd.wr_size;
                    seg_next.free = cmd.wr_free;
                end
                else if (lo.hit)
                begin
                    seg_next = '{valid: 1'b1, offset: cmd.new_offset,
                                 size: cmd.new_size, free: 1'b1};
                end
                else if (!vis_reg)
                begin
                    seg_next = lo.seg;
                end
            end
            OP_REMOVE_AFTER:
            begin
                if (hit_reg)
                begin
                    seg_next.size = cmd.wr_size;
                    seg_next.free = cmd.wr_free;
                end
                else if (!vis_reg)
                begin
                    seg_next = hi.seg;
                end
            end
            OP_REMOVE_HIT:
            begin
                if (hi.hit)
                begin
                    seg_next.size = cmd.wr_size;
                    seg_next.free = cmd.wr_free;
                end
                else if (hit_reg || !vis_reg)
                begin
                    seg_next = hi.seg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= RESET_SEG;
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
            vis_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            tok_reg <= tok_next;
            hit_reg <= hit_next;
            vis_reg <= vis_next;
        end
    end

    assign me = '{seg: seg_reg, tok: tok_reg, hit: hit_reg};

endmodule

// ===== design/ffba_ctrl.sv =====
`timescale 1ns / 1ps
`include "first_fit_block_allocator_assert.svh"
module ffba_ctrl #(
    parameter int HEADER_BYTES = 24,
    parameter int MAX_SEGS     = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    ffba_req_if.sink            request,
    ffba_rsp_if.source          response,
    input  ffba_pkg::seg_t      cur_seg,
    output ffba_pkg::cell_cmd_t cmd
);
    import ffba_pkg::*;

    localparam int CW = $clog2(MAX_SEGS + 1);
    localparam logic [SEG_W-1:0] HDR = SEG_W'(HEADER_BYTES);

    state_t           state_reg, state_next;
    logic             mode_reg;
    logic [13:0]      req_reg;
    logic [12:0]      addr_reg;
    seg_t             found_reg, prev_reg, next_reg;
    logic [SEG_W-1:0] msz_reg;
    logic [CW-1:0]    count_reg;
    status_t          status_reg;
    logic [12:0]      gaddr_reg;
    logic [13:0]      gsize_reg;

    logic             miss, match, split, full, merge_n, merge_p;
    logic [SEG_W-1:0] req_ext, msz;
    logic [SEG_W:0]   split_need;

    // Decode the cell under the token
    always_comb
    begin
        req_ext    = SEG_W'(req_reg);
        split_need = {1'b0, req_ext} + {1'b0, HDR} + (SEG_W+1)'(1);
        miss       = !cur_seg.valid;
        match      = mode_reg ? ((cur_seg.offset == SEG_W'(addr_reg)) && !cur_seg.free)
                              : (cur_seg.free && (cur_seg.size >= req_ext));
        split      = {1'b0, found_reg.size} >= split_need;
        full       = count_reg >= CW'(MAX_SEGS);
        merge_n    = next_reg.valid && next_reg.free;
        merge_p    = prev_reg.valid && prev_reg.free;
        msz        = merge_n ? (found_reg.size + next_reg.size + HDR) : found_reg.size;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (request.valid) state_next = S_SCAN;
            S_SCAN:
            begin
                if (miss)       state_next = S_RESP;
                else if (match) state_next = mode_reg ? S_NEXT : S_ALLOC;
            end
            S_NEXT:   state_next = S_FREE_A;
            S_FREE_A: state_next = S_FREE_B;
            S_FREE_B: state_next = S_RESP;
            S_ALLOC:  state_next = S_RESP;
            S_RESP:   if (response.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs: handshakes and cell commands
    always_comb
    begin
        request.ready  = (state_reg == S_IDLE);
        response.valid = (state_reg == S_RESP);
        cmd            = '0;
        cmd.op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:   cmd.start = request.valid;
            S_SCAN:
            begin
                cmd.shift_tok = !miss;
                cmd.latch_hit = !miss && match;
            end
            S_ALLOC:
            begin
                cmd.wr_free = 1'b0;
                if (split)
                begin
                    cmd.op         = full ? OP_NOP : OP_INSERT;
                    cmd.wr_size    = req_ext;
                    cmd.new_offset = found_reg.offset + HDR + req_ext;
                    cmd.new_size   = found_reg.size - req_ext - HDR;
                end
                else
                begin
                    cmd.op      = OP_SET_HIT;
                    cmd.wr_size = found_reg.size;
                end
            end
            S_FREE_A:
            begin
                cmd.op      = merge_n ? OP_REMOVE_AFTER : OP_SET_HIT;
                cmd.wr_size = msz;
                cmd.wr_free = 1'b1;
            end
            S_FREE_B:
            begin
                cmd.op      = merge_p ? OP_REMOVE_HIT : OP_NOP;
                cmd.wr_size = prev_reg.size + msz_reg + HDR;
                cmd.wr_free = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign response.status          = status_reg;
    assign response.granted_address = gaddr_reg;
    assign response.granted_size    = gsize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ALLOC && split && !full)
                count_reg <= count_reg + CW'(1);
            else if ((state_reg == S_FREE_A && merge_n) || (state_reg == S_FREE_B && merge_p))
                count_reg <= count_reg - CW'(1);
        end
    end

    // Capture the word, track scan neighbors, build the result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                mode_reg <= request.mode;
                req_reg  <= request.request_size;
                addr_reg <= request.block_address;
                prev_reg <= '0;
            end
            S_SCAN:
            begin
                if (miss)
                begin
                    status_reg <= mode_reg ? ST_BAD_ADDRESS : ST_NO_SPACE;
                    gaddr_reg  <= '0;
                    gsize_reg  <= '0;
                end
                else if (match)
                    found_reg <= cur_seg;
                else
                    prev_reg <= cur_seg;
            end
            S_NEXT:   next_reg <= cur_seg;
            S_FREE_A:
            begin
                msz_reg    <= msz;
                status_reg <= ST_OK;
                gaddr_reg  <= '0;
                gsize_reg  <= found_reg.size[13:0];
            end
            S_ALLOC:
            begin
                if (split && full)
                begin
                    status_reg <= ST_TABLE_FULL;
                    gaddr_reg  <= '0;
                    gsize_reg  <= '0;
                end
                else
                begin
                    status_reg <= ST_OK;
                    gaddr_reg  <= found_reg.offset[12:0];
                    gsize_reg  <= split ? req_reg : found_reg.size[13:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    `FFBA_ASSERT(a_count_range, (count_reg >= CW'(1)) && (count_reg <= CW'(MAX_SEGS)))
    `FFBA_ASSERT(a_one_side, !(request.ready && response.valid))
    `FFBA_ASSERT(a_err_zero, !response.valid || status_reg == ST_OK || (gaddr_reg == '0 && gsize_reg == '0))
    `FFBA_ASSERT_NEXT(a_alloc_done, state_reg == S_ALLOC, state_reg == S_RESP)

endmodule

// ===== design/first_fit_block_allocator.sv =====
// First-fit arena allocator: a chain of MAX_SEGS cells holds the address-ordered segment
// table, and a scan token walks it one cell per clock. After the scan, an allocate passes
// through S_ALLOC and a free through S_NEXT, S_FREE_A and S_FREE_B before S_RESP, where
// the response is held until it is accepted. A request that finds no match walks all n
// live segments and then answers. A new word is taken only after the previous response
// has been accepted. Status 0 ok, 1 no space, 2 table full, 3 bad address; on error
// granted address and size are zero.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
    parameter int ARENA_BYTES  = 8192,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_SEGS     = 64
) (
    input logic        clk,
    input logic        rst_n,
    ffba_req_if.sink   request,
    ffba_rsp_if.source response
);
    import ffba_pkg::*;

    link_t     lnk [MAX_SEGS];
    cell_cmd_t cmd;
    seg_t      cur_seg;

    // Cell chain
    for (genvar k = 0; k < MAX_SEGS; k++)
    begin : g_cell
        link_t lo, hi;
        assign lo = (k == 0) ? link_t'('0) : lnk[(k == 0) ? 0 : k - 1];
        assign hi = (k == MAX_SEGS - 1) ? link_t'('0) : lnk[(k == MAX_SEGS - 1) ? k : k + 1];
        ffba_cell #(
            .IS_FIRST  (k == 0),
            .INIT_SIZE (ARENA_BYTES - HEADER_BYTES)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .lo    (lo),
            .hi    (hi),
            .me    (lnk[k])
        );
    end

    // Select the cell holding the token
    always_comb
    begin
        cur_seg = '0;
        for (int k = 0; k < MAX_SEGS; k++)
            cur_seg = cur_seg | (lnk[k].tok ? lnk[k].seg : seg_t'('0));
    end

    ffba_ctrl #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SEGS     (MAX_SEGS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cur_seg  (cur_seg),
        .cmd      (cmd)
    );

endmodule

// ===== tb/sv/first_fit_block_allocator_tb.sv =====
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int ARENA  = 8192;
    localparam int HDR    = 24;
    localparam int NSEGS  = 64;
    localparam int LIMIT  = 20000;
    localparam int NRAND  = 360;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct {
        logic        mode;
        logic [13:0] size;
        logic [12:0] addr;
        logic        typed;   // expected result given in the row
        status_t     st;
        logic [12:0] gaddr;
        logic [13:0] gsize;
    } stim_row_t;

    typedef struct {
        status_t     st;
        logic [12:0] gaddr;
        logic [13:0] gsize;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    ffba_req_if request ();
    ffba_rsp_if response ();

    first_fit_block_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request.sink),
        .response (response.source)
    );

    always #1 clk = ~clk;

    // Segment table mirror
    int seg_off [NSEGS];
    int seg_len [NSEGS];
    bit seg_fre [NSEGS];
    int seg_cnt;

    grant_t expected_grants[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    stim_row_t rows[$];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void table_reset();
        seg_cnt = 1;
        seg_off[0] = 0;
        seg_len[0] = ARENA - HDR;
        seg_fre[0] = 1'b1;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int k = idx; k + 1 < seg_cnt; k++) begin
            seg_off[k] = seg_off[k + 1];
            seg_len[k] = seg_len[k + 1];
            seg_fre[k] = seg_fre[k + 1];
        end
        seg_cnt--;
    endfunction

    function automatic grant_t allocate_or_release(input logic mode, input int req,
                                                   input int addr);
        grant_t g;
        int hit;
        g.st = ST_OK;
        g.gaddr = '0;
        g.gsize = '0;
        hit = -1;
        if (mode == MODE_ALLOC) begin
            for (int i = 0; i < seg_cnt; i++)
                if (hit < 0 && seg_fre[i] && seg_len[i] >= req) hit = i;
            if (hit < 0) g.st = ST_NO_SPACE;
            else if (seg_len[hit] >= req + HDR + 1) begin
                if (seg_cnt >= NSEGS) g.st = ST_TABLE_FULL;
                else begin
                    for (int k = seg_cnt; k > hit + 1; k--) begin
                        seg_off[k] = seg_off[k - 1];
                        seg_len[k] = seg_len[k - 1];
                        seg_fre[k] = seg_fre[k - 1];
                    end
                    seg_cnt++;
                    seg_off[hit + 1] = seg_off[hit] + HDR + req;
                    seg_len[hit + 1] = seg_len[hit] - req - HDR;
                    seg_fre[hit + 1] = 1'b1;
                    seg_len[hit] = req;
                    seg_fre[hit] = 1'b0;
                    g.gaddr = 13'(seg_off[hit]);
                    g.gsize = 14'(req);
                end
            end else begin
                seg_fre[hit] = 1'b0;
                g.gaddr = 13'(seg_off[hit]);
                g.gsize = 14'(seg_len[hit]);
            end
        end else begin
            for (int i = 0; i < seg_cnt; i++)
                if (hit < 0 && seg_off[i] == addr && !seg_fre[i]) hit = i;
            if (hit < 0) g.st = ST_BAD_ADDRESS;
            else begin
                g.gsize = 14'(seg_len[hit]);
                seg_fre[hit] = 1'b1;
                if (hit + 1 < seg_cnt && seg_fre[hit + 1]) begin
                    seg_len[hit] += seg_len[hit + 1] + HDR;
                    drop_entry(hit + 1);
                end
                if (hit > 0 && seg_fre[hit - 1]) begin
                    seg_len[hit - 1] += seg_len[hit] + HDR;
                    drop_entry(hit);
                end
            end
        end
        return g;
    endfunction

    // Pick a used segment start most of the time, else a random address
    function automatic int pick_used();
        int k;
        if (seg_cnt > 1 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, seg_cnt - 1);
            for (int j = 0; j < seg_cnt; j++)
                if (!seg_fre[(k + j) % seg_cnt]) return seg_off[(k + j) % seg_cnt];
        end
        return $urandom_range(0, 8191);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    function automatic stim_row_t row(input logic m, input int s, input int a);
        stim_row_t r;
        r.mode = m;
        r.size = 14'(s);
        r.addr = 13'(a);
        r.typed = 1'b0;
        r.st = ST_OK;
        r.gaddr = '0;
        r.gsize = '0;
        return r;
    endfunction

    function automatic stim_row_t row_exp(input logic m, input int s, input int a,
                                          input status_t st, input int ga, input int gs);
        stim_row_t r;
        r = row(m, s, a);
        r.typed = 1'b1;
        r.st = st;
        r.gaddr = 13'(ga);
        r.gsize = 14'(gs);
        return r;
    endfunction

    // Send one word and queue its expectation
    task automatic send_word(input stim_row_t r);
        grant_t g;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid <= 1'b1;
        request.mode <= r.mode;
        request.request_size <= r.size;
        request.block_address <= r.addr;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
        g = allocate_or_release(r.mode, r.size, r.addr);
        if (r.typed) begin
            if (g.st != r.st) report("row status", g.st, r.st);
            if (g.gaddr != r.gaddr) report("row granted_address", g.gaddr, r.gaddr);
            if (g.gsize != r.gsize) report("row granted_size", g.gsize, r.gsize);
        end
        expected_grants.push_back(g);
    endtask

    // Stimulus
    initial begin
        stim_row_t r;
        int s;
        request.valid = 1'b0;
        request.mode = MODE_ALLOC;
        request.request_size = '0;
        request.block_address = '0;
        table_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(row_exp(MODE_FREE, 0, 0, ST_BAD_ADDRESS, 0, 0));
        rows.push_back(row_exp(MODE_ALLOC, 8192, 0, ST_NO_SPACE, 0, 0));
        rows.push_back(row_exp(MODE_ALLOC, 16383, 0, ST_NO_SPACE, 0, 0));
        rows.push_back(row_exp(MODE_ALLOC, 0, 0, ST_OK, 0, 0));
        rows.push_back(row_exp(MODE_ALLOC, 100, 0, ST_OK, 24, 100));
        rows.push_back(row(MODE_ALLOC, 200, 0));
        rows.push_back(row(MODE_FREE, 0, 24));
        rows.push_back(row(MODE_FREE, 0, 24));          // double free
        rows.push_back(row(MODE_ALLOC, 90, 0));         // small remainder, whole segment
        rows.push_back(row(MODE_FREE, 0, 8191));
        rows.push_back(row(MODE_FREE, 0, 0));           // next segment in use, no merge
        rows.push_back(row(MODE_FREE, 0, 148));         // merge forward
        rows.push_back(row(MODE_ALLOC, 8168, 0));       // whole arena
        rows.push_back(row(MODE_ALLOC, 0, 0));
        rows.push_back(row(MODE_FREE, 0, 0));
        rows.push_back(row(MODE_ALLOC, 8144, 0));       // no free segment large enough
        rows.push_back(row(MODE_FREE, 0, 0));
        rows.push_back(row(MODE_ALLOC, 8143, 0));       // no free segment large enough
        rows.push_back(row(MODE_FREE, 0, 0));
        foreach (rows[i]) send_word(rows[i]);

        // Fill the table to force table_full, then release
        for (int i = 0; i < 66; i++) send_word(row(MODE_ALLOC, $urandom_range(0, 40), 0));
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++) send_word(row(MODE_FREE, 0, pick_used()));
        hold_off = 1'b0;

        for (int i = 0; i < NRAND; i++) begin
            s = $urandom_range(0, 9);
            if (s < 5) begin
                if ($urandom_range(0, 9) == 0) r = row(MODE_ALLOC, $urandom_range(0, 16383), 0);
                else if ($urandom_range(0, 4) == 0)
                    r = row(MODE_ALLOC, $urandom_range(1000, 8192), $urandom_range(0, 8191));
                else r = row(MODE_ALLOC, $urandom_range(0, 300), $urandom_range(0, 8191));
            end else begin
                r = row(MODE_FREE, $urandom_range(0, 16383), pick_used());
            end
            send_word(r);
        end
        request.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver readiness, with one long hold-off after the table is filled
    initial begin
        int gap;
        response.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                response.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            response.ready <= 1'b1;
            @(posedge clk);
            gap = gap_len();
            if (gap > 0) begin
                response.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Compare results and watch for a stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (response.valid && response.ready) begin
                grant_t g;
                if (expected_grants.size() == 0) begin
                    report("words outstanding", 0, 1);
                end else begin
                    g = expected_grants.pop_front();
                    if (response.status != g.st) report("status", response.status, g.st);
                    if (response.granted_address != g.gaddr)
                        report("granted_address", response.granted_address, g.gaddr);
                    if (response.granted_size != g.gsize)
                        report("granted_size", response.granted_size, g.gsize);
                end
            end
            if ((response.valid && response.ready) || (request.valid && request.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run
    initial begin
        @(posedge rst_n);
        while (!(stim_done && expected_grants.size() == 0) && idle_cycles < LIMIT)
            @(posedge clk);
        if (idle_cycles >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            repeat (200) @(posedge clk);
            if (errors == 0) $display("ALL CHECKS PASSED");
            else $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule

// ===== sim.f =====
+incdir+design
design/ffba_pkg.sv
design/ffba_req_if.sv
design/ffba_rsp_if.sv
design/ffba_cell.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator.sv
tb/sv/first_fit_block_allocator_tb.sv
